// ----- src/smpq_pkg.sv -----
package smpq_pkg;

    localparam int DEPTH_DEF          = 16;
    localparam int PRIORITY_WIDTH_DEF = 32;
    localparam int PAYLOAD_WIDTH_DEF  = 16;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

// ----- src/smpq_cell.sv -----
module smpq_cell
    import smpq_pkg::*;
#(
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic                      i_occupied,
    input  logic [PRIORITY_WIDTH-1:0] i_new_prio,
    input  logic [PAYLOAD_WIDTH-1:0]  i_new_payload,
    input  logic                      i_left_gt,
    input  logic [PRIORITY_WIDTH-1:0] i_left_prio,
    input  logic [PAYLOAD_WIDTH-1:0]  i_left_payload,
    input  logic [PRIORITY_WIDTH-1:0] i_right_prio,
    input  logic [PAYLOAD_WIDTH-1:0]  i_right_payload,
    output logic                      o_gt,
    output logic [PRIORITY_WIDTH-1:0] o_prio,
    output logic [PAYLOAD_WIDTH-1:0]  o_payload
);

    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic [PAYLOAD_WIDTH-1:0]  r_payload;
    logic [PRIORITY_WIDTH-1:0] n_prio;
    logic [PAYLOAD_WIDTH-1:0]  n_payload;

    // an empty cell counts as larger than anything
    assign o_gt = !i_occupied || (r_prio > i_new_prio);

    always_comb begin
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_ctrl.pop) begin
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end else if (i_ctrl.push && o_gt) begin
            if (i_left_gt) begin
                n_prio    = i_left_prio;
                n_payload = i_left_payload;
            end else begin
                n_prio    = i_new_prio;
                n_payload = i_new_payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_prio    = r_prio;
    assign o_payload = r_payload;

endmodule

// ----- src/stable_min_priority_queue.sv -----
// The result of an accepted request is written into the output register at the next clock.
// Throughput: one request per cycle while each result is taken; every cell compares against
// the pushed key and shifts in the same cycle, so the cell row never holds the flow.
// A new request is taken while the previous result waits, as long as it is taken too.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// slot contents are not reset and are only read below the entry count.
module stable_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH          = DEPTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEF,
    localparam int COUNT_WIDTH   = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_action,
    input  logic [PRIORITY_WIDTH-1:0] i_priority_req,
    input  logic [PAYLOAD_WIDTH-1:0]  i_payload,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [PAYLOAD_WIDTH-1:0]  o_popped_payload,
    output logic                      o_is_empty,
    output logic [COUNT_WIDTH-1:0]    o_entry_count
);

    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

    // fill count: cells below it hold live entries, head is cell 0
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    // result register
    logic                     r_out_valid;
    t_status                  r_status;
    logic [PAYLOAD_WIDTH-1:0] r_popped;
    logic                     r_empty;
    logic [COUNT_WIDTH-1:0]   r_count_out;

    t_status                  n_status;
    logic [PAYLOAD_WIDTH-1:0] n_popped;
    t_cell_ctrl               w_ctrl;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_nonempty;

    logic [PRIORITY_WIDTH-1:0] w_prio    [DEPTH];
    logic [PAYLOAD_WIDTH-1:0]  w_payload [DEPTH];
    logic                      w_gt      [DEPTH];

    // output register frees up when its result is taken in the same cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == FULL_COUNT);
    assign w_nonempty = (r_count != '0);

    // decode the request; refused pushes and empty pops touch no cell
    always_comb begin
        w_ctrl   = '0;
        n_count  = r_count;
        n_status = ST_DONE;
        n_popped = '0;
        case (i_action)
            ACT_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.push = w_accept;
                    n_count     = r_count + COUNT_WIDTH'(1);
                end
            end
            ACT_POP: begin
                if (!w_nonempty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctrl.pop = w_accept;
                    n_popped   = w_payload[0];
                    n_count    = r_count - COUNT_WIDTH'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused code: no operation
            end
        endcase
    end

    // row of compare-and-shift cells; a push ripples the larger entries one
    // cell to the right and drops the new one in at the first larger key,
    // a pop moves everything one cell toward the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                      w_left_gt;
        logic [PRIORITY_WIDTH-1:0] w_left_prio;
        logic [PAYLOAD_WIDTH-1:0]  w_left_payload;
        logic [PRIORITY_WIDTH-1:0] w_right_prio;
        logic [PAYLOAD_WIDTH-1:0]  w_right_payload;

        if (g == 0) begin : g_head
            assign w_left_gt      = 1'b0;
            assign w_left_prio    = '0;
            assign w_left_payload = '0;
        end else begin : g_mid
            assign w_left_gt      = w_gt[g-1];
            assign w_left_prio    = w_prio[g-1];
            assign w_left_payload = w_payload[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_prio    = '0;
            assign w_right_payload = '0;
        end else begin : g_body
            assign w_right_prio    = w_prio[g+1];
            assign w_right_payload = w_payload[g+1];
        end

        smpq_cell #(
            .PRIORITY_WIDTH (PRIORITY_WIDTH),
            .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctrl          (w_ctrl),
            .i_occupied      (COUNT_WIDTH'(g) < r_count),
            .i_new_prio      (i_priority_req),
            .i_new_payload   (i_payload),
            .i_left_gt       (w_left_gt),
            .i_left_prio     (w_left_prio),
            .i_left_payload  (w_left_payload),
            .i_right_prio    (w_right_prio),
            .i_right_payload (w_right_payload),
            .o_gt            (w_gt[g]),
            .o_prio          (w_prio[g]),
            .o_payload       (w_payload[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status    <= n_status;
            r_popped    <= n_popped;
            r_empty     <= (n_count == '0);
            r_count_out <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_popped_payload = r_popped;
    assign o_is_empty       = r_empty;
    assign o_entry_count    = r_count_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_POP && w_nonempty)
        |=> (r_count == $past(r_count) - COUNT_WIDTH'(1)))
        else $error("pop did not remove one entry");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_PUSH && w_full)
        |=> (r_status == ST_FULL && r_count == FULL_COUNT))
        else $error("push on full queue not refused");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule
